// ===== rtl/core/rba_pkg.sv =====
// ----------------------------------------------------------------------------
// rba_pkg: shared constants, types and helpers for the room booking allocator
// Sizes of the room store, time and count widths, store port structs and the
// output formatting functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rba_pkg;

   // Built room count and internal time width
   localparam int MAX_ROOMS     = 16;
   localparam int TIME_BITS     = 48;

   // Derived widths
   localparam int ROOM_BITS     = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
   localparam int ACT_BITS      = $clog2(MAX_ROOMS + 1);
   localparam int COUNT_BITS    = 16;
   localparam int OUT_TIME_BITS = 48;
   localparam int OUT_ROOM_BITS = 4;
   localparam int CFG_BITS      = 5;
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 112;

   localparam logic [CFG_BITS-1:0]      ROOM_COUNT_RESET = CFG_BITS'(16);
   localparam logic [COUNT_BITS-1:0]    COUNT_MAX        = '1;
   localparam logic [OUT_TIME_BITS-1:0] OUT_TIME_MAX     = '1;

   // One room entry of the store
   typedef struct packed {
      logic [TIME_BITS-1:0]  free_at;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // Control from the sequencer to the store
   typedef struct packed {
      logic                 clear;
      logic                 rd_en;
      logic [ROOM_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ROOM_BITS-1:0] wr_addr;
      entry_type            wr_data;
   } store_req_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   // Clip an internal time to the 48-bit output field
   function automatic logic [OUT_TIME_BITS-1:0] out_time(input logic [TIME_BITS-1:0] t);
      logic [63:0] w;
      w = 64'(t);
      if (w > 64'(OUT_TIME_MAX)) begin
         return OUT_TIME_MAX;
      end
      return w[OUT_TIME_BITS-1:0];
   endfunction

   // Low bits of a room index for the output fields
   function automatic logic [OUT_ROOM_BITS-1:0] room_out(input logic [ROOM_BITS-1:0] idx);
      logic [63:0] w;
      w = 64'(idx);
      return w[OUT_ROOM_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rba_store.sv =====
// ----------------------------------------------------------------------------
// rba_store: room state memory
// One entry per room holding free-at time and booking count. Synchronous
// registered read; per-entry valid bits make a cleared or never written
// entry read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rba_store (
   input  wire                         clock,
   input  wire                         reset,
   input  wire rba_pkg::store_req_type req,
   output rba_pkg::entry_type          rd_entry
);

   rba_pkg::entry_type                 mem_ff [rba_pkg::MAX_ROOMS];
   rba_pkg::entry_type                 rd_data_ff;
   logic                               rd_valid_ff;
   logic [rba_pkg::MAX_ROOMS-1:0]      valid_ff;
   logic [rba_pkg::MAX_ROOMS-1:0]      valid_in;

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff  <= mem_ff[req.rd_addr];
         rd_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   // Valid bits: clear drops all, a write sets its entry
   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/core/room_booking_allocator.sv =====
// ----------------------------------------------------------------------------
// room_booking_allocator: assigns jobs to rooms (meeting rooms III scheme)
// Each job goes to the lowest free room, or else to the room that frees
// first and is pushed back; reports the running most-booked room.
//
//   channel  dir  handshake            payload
//   req_     in   tvalid/tready        start_time, end_time, clear_first
//   rsp_     out  tvalid/tready        room, actual_start, actual_finish,
//                                      delayed, most_booked_room
//   csr_     in   wr_en                room_count
//
// The store is read one room per cycle through its single read port, then
// the chosen room is written back. Reset is synchronous; it clears the store
// through valid bits at once. The next job is taken while a result waits on
// rsp_; a job only stalls in its write-back cycle while the previous result
// is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module room_booking_allocator (
   input  wire                                clock,
   input  wire                                reset,
   // tdata: start_time[31:0], end_time[63:32], clear_first[64], zero pad
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [rba_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tdata: room[3:0], actual_start[51:4], actual_finish[99:52],
   //        delayed[100], most_booked_room[104:101], zero pad
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [rba_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  wire                                csr_wr_en,
   input  wire  [rba_pkg::CFG_BITS-1:0]       csr_wr_data
);

   localparam int TB = rba_pkg::TIME_BITS;
   localparam int RB = rba_pkg::ROOM_BITS;
   localparam int AB = rba_pkg::ACT_BITS;
   localparam int CB = rba_pkg::COUNT_BITS;

   // Request fields
   logic [31:0] req_start;
   logic [31:0] req_end;
   logic        req_clear;

   assign req_start = req_tdata[31:0];
   assign req_end   = req_tdata[63:32];
   assign req_clear = req_tdata[64];

   rba_pkg::state_type          state_ff, state_in;
   logic [rba_pkg::CFG_BITS-1:0] room_count_ff;
   logic [AB-1:0]               active_ff, active_in;
   logic [TB-1:0]               start_ff, start_in;
   logic [31:0]                 dur_ff, dur_in;
   logic [AB-1:0]               issue_ff, issue_in;
   logic                        rdv_ff, rdv_in;
   logic [RB-1:0]               rd_idx_ff, rd_idx_in;
   logic                        found_ff, found_in;
   logic [RB-1:0]               f_idx_ff, f_idx_in;
   logic [CB-1:0]               f_cnt_ff, f_cnt_in;
   logic [RB-1:0]               m_idx_ff, m_idx_in;
   logic [TB-1:0]               m_free_ff, m_free_in;
   logic [CB-1:0]               m_cnt_ff, m_cnt_in;
   logic [RB-1:0]               best_room_ff, best_room_in;
   logic [CB-1:0]               best_cnt_ff, best_cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rba_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   rba_pkg::store_req_type      st_req;
   rba_pkg::entry_type          rd_entry;

   // Update-cycle datapath
   logic [RB-1:0] pick;
   logic [TB-1:0] begin_t;
   logic [CB-1:0] pick_cnt;
   logic [CB-1:0] new_cnt;
   logic [TB:0]   sum;
   logic [TB-1:0] finish;
   logic          best_take;
   logic          upd_go;
   logic [7:0]    rc_wide;
   logic [AB-1:0] active_clamp;

   rba_store u_store (
      .clock    (clock),
      .reset    (reset),
      .req      (st_req),
      .rd_entry (rd_entry)
   );

   // Active room count from the register: zero means one, clipped to the build
   always_comb begin
      rc_wide = 8'(room_count_ff);
      if (rc_wide == 8'd0) begin
         active_clamp = AB'(1);
      end else if (rc_wide > 8'(rba_pkg::MAX_ROOMS)) begin
         active_clamp = AB'(rba_pkg::MAX_ROOMS);
      end else begin
         active_clamp = AB'(rc_wide);
      end
   end

   // Choice of room and new values for the write-back
   always_comb begin
      pick     = found_ff ? f_idx_ff : m_idx_ff;
      begin_t  = found_ff ? start_ff : m_free_ff;
      pick_cnt = found_ff ? f_cnt_ff : m_cnt_ff;
      sum      = {1'b0, begin_t} + (TB+1)'(dur_ff);
      finish   = sum[TB] ? '1 : sum[TB-1:0];
      new_cnt  = (pick_cnt == rba_pkg::COUNT_MAX) ? pick_cnt : pick_cnt + 1'b1;
      best_take = (new_cnt > best_cnt_ff) ||
                  ((new_cnt == best_cnt_ff) && (pick < best_room_ff));
   end

   assign req_tready = (state_ff == rba_pkg::ST_IDLE);
   assign upd_go     = (state_ff == rba_pkg::ST_UPDATE) && (!rsp_valid_ff || rsp_tready);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      start_in     = start_ff;
      dur_in       = dur_ff;
      issue_in     = issue_ff;
      rdv_in       = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      f_idx_in     = f_idx_ff;
      f_cnt_in     = f_cnt_ff;
      m_idx_in     = m_idx_ff;
      m_free_in    = m_free_ff;
      m_cnt_in     = m_cnt_ff;
      best_room_in = best_room_ff;
      best_cnt_in  = best_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      st_req       = '0;

      case (state_ff)
         rba_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               start_in  = TB'(req_start);
               dur_in    = (req_end > req_start) ? req_end - req_start : 32'd0;
               active_in = active_clamp;
               issue_in  = '0;
               found_in  = 1'b0;
               st_req.clear = req_clear;
               if (req_clear) begin
                  best_room_in = '0;
                  best_cnt_in  = '0;
               end
               state_in = rba_pkg::ST_SCAN;
            end
         end
         rba_pkg::ST_SCAN: begin
            // issue one read per cycle
            if (issue_ff < active_ff) begin
               st_req.rd_en   = 1'b1;
               st_req.rd_addr = issue_ff[RB-1:0];
               rd_idx_in      = issue_ff[RB-1:0];
               rdv_in         = 1'b1;
               issue_in       = issue_ff + 1'b1;
            end
            // evaluate the entry read last cycle
            if (rdv_ff) begin
               if (!found_ff && (rd_entry.free_at <= start_ff)) begin
                  found_in = 1'b1;
                  f_idx_in = rd_idx_ff;
                  f_cnt_in = rd_entry.count;
               end
               if ((rd_idx_ff == '0) || (rd_entry.free_at < m_free_ff)) begin
                  m_idx_in  = rd_idx_ff;
                  m_free_in = rd_entry.free_at;
                  m_cnt_in  = rd_entry.count;
               end
            end else if (issue_ff == active_ff) begin
               state_in = rba_pkg::ST_UPDATE;
            end
         end
         rba_pkg::ST_UPDATE: begin
            if (upd_go) begin
               st_req.wr_en           = 1'b1;
               st_req.wr_addr         = pick;
               st_req.wr_data.free_at = finish;
               st_req.wr_data.count   = new_cnt;
               if (best_take) begin
                  best_room_in = pick;
                  best_cnt_in  = new_cnt;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = rba_pkg::RSP_DATA_BITS'({
                  rba_pkg::room_out(best_take ? pick : best_room_ff),
                  !found_ff,
                  rba_pkg::out_time(finish),
                  rba_pkg::out_time(begin_t),
                  rba_pkg::room_out(pick)});
               state_in = rba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rba_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rba_pkg::ST_IDLE;
         rdv_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_room_ff  <= '0;
         best_cnt_ff   <= '0;
         room_count_ff <= rba_pkg::ROOM_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
         best_room_ff <= best_room_in;
         best_cnt_ff  <= best_cnt_in;
         if (csr_wr_en) begin
            room_count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      active_ff   <= active_in;
      start_ff    <= start_in;
      dur_ff      <= dur_in;
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      found_ff    <= found_in;
      f_idx_ff    <= f_idx_in;
      f_cnt_ff    <= f_cnt_in;
      m_idx_ff    <= m_idx_in;
      m_free_ff   <= m_free_in;
      m_cnt_ff    <= m_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for room_booking_allocator
// Drives job requests on req_, room counts on csr_, and checks every result on
// rsp_ against an in-bench room allocator or a hand-written booking. A short
// directed table comes first, then a run of long back to back jobs on one room,
// then random phases over room counts; all but one idle at random on both sides.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rba_pkg::*;

   localparam int QUIET_LIMIT  = 5000;   // cycles with no transaction at all
   localparam int SOAK_JOBS    = 24;     // long jobs piling up on one room
   localparam int PHASE_JOBS   = 114;
   localparam int SPACING      = 16;     // largest start step of in-order random jobs
   localparam int REPORT_LIMIT = 10;

   typedef logic [TIME_BITS-1:0] stamp_t;

   typedef struct packed {
      logic [31:0] start_time;
      logic [31:0] end_time;
      logic        clear_first;
   } booking_request_t;

   typedef struct packed {
      logic [3:0]               room;
      logic [OUT_TIME_BITS-1:0] actual_start;
      logic [OUT_TIME_BITS-1:0] actual_finish;
      logic                     delayed;
      logic [3:0]               most_booked;
   } booking_t;

   typedef enum logic {ROW_JOB, ROW_CSR} row_kind_t;

   typedef struct packed {
      row_kind_t        kind;
      logic [4:0]       rooms;       // room count for csr rows
      booking_request_t request;
      logic             typed;       // expected booking written out by hand
      booking_t         booking;
   } plan_row_t;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_wr_en;
   logic [CFG_BITS-1:0]      csr_wr_data;

   // hand-written expectation travels alongside the request
   logic     typed_valid;
   booking_t typed_booking;

   // allocator mirror
   stamp_t          room_free_at  [MAX_ROOMS];
   logic [15:0]     room_bookings [MAX_ROOMS];
   int              busiest_room;
   logic [15:0]     busiest_count;
   logic [4:0]      rooms_setting;

   booking_t        expected_bookings [$];
   int unsigned     jobs_sent     = 0;
   int unsigned     results_seen  = 0;
   int unsigned     failures      = 0;
   bit              calm          = 1'b0;   // no idling on either side
   logic [31:0]     cursor        = '0;     // last start of the random stream
   plan_row_t       directed_plan [$];
   logic [4:0]      phase_rooms   [0:7];

   room_booking_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Allocator mirror
   // ---------------------------------------------------------------------------
   function automatic void clear_rooms();
      for (int i = 0; i < MAX_ROOMS; i++) begin
         room_free_at[i]  = '0;
         room_bookings[i] = '0;
      end
      busiest_room  = 0;
      busiest_count = '0;
   endfunction

   function automatic booking_t allocate_room(input booking_request_t job);
      booking_t           b;
      logic [31:0]        span;
      int                 active;
      int                 pick;
      bit                 found;
      logic [TIME_BITS:0] total;
      if (job.clear_first) clear_rooms();
      span   = (job.end_time > job.start_time) ? job.end_time - job.start_time : '0;
      active = (rooms_setting == 0) ? 1 :
               (rooms_setting > MAX_ROOMS) ? MAX_ROOMS : int'(rooms_setting);
      found  = 1'b0;
      pick   = 0;
      // lowest active room already free at the requested start
      for (int i = 0; i < active; i++) begin
         if (!found && room_free_at[i] <= stamp_t'(job.start_time)) begin
            pick  = i;
            found = 1'b1;
         end
      end
      // otherwise the room that frees first, lower index on ties
      if (!found) begin
         for (int i = 1; i < active; i++) begin
            if (room_free_at[i] < room_free_at[pick]) pick = i;
         end
      end
      b.delayed      = !found;
      b.actual_start = found ? stamp_t'(job.start_time) : room_free_at[pick];
      total          = {1'b0, b.actual_start} + span;
      b.actual_finish = total[TIME_BITS] ? '1 : total[TIME_BITS-1:0];
      room_free_at[pick] = b.actual_finish;
      if (room_bookings[pick] != '1) room_bookings[pick] = room_bookings[pick] + 1'b1;
      if (room_bookings[pick] > busiest_count ||
          (room_bookings[pick] == busiest_count && pick < busiest_room)) begin
         busiest_count = room_bookings[pick];
         busiest_room  = pick;
      end
      b.room        = 4'(pick);
      b.most_booked = 4'(busiest_room);
      return b;
   endfunction

   // ---------------------------------------------------------------------------
   // Scoreboard: predict on each request transaction, check each result
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      booking_request_t job;
      booking_t         want;
      booking_t         seen;
      if (reset) begin
         clear_rooms();
         rooms_setting = ROOM_COUNT_RESET;
      end else begin
         if (csr_wr_en) rooms_setting = csr_wr_data;
         if (req_tvalid && req_tready) begin
            job.start_time  = req_tdata[31:0];
            job.end_time    = req_tdata[63:32];
            job.clear_first = req_tdata[64];
            want = allocate_room(job);
            if (typed_valid) want = typed_booking;
            expected_bookings.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            seen.room          = rsp_tdata[3:0];
            seen.actual_start  = rsp_tdata[51:4];
            seen.actual_finish = rsp_tdata[99:52];
            seen.delayed       = rsp_tdata[100];
            seen.most_booked   = rsp_tdata[104:101];
            if (expected_bookings.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: result with no booking pending: room %0d start %0h",
                           $realtime, seen.room, seen.actual_start);
            end else begin
               want = expected_bookings.pop_front();
               if (seen.room !== want.room || seen.actual_start !== want.actual_start ||
                   seen.actual_finish !== want.actual_finish ||
                   seen.delayed !== want.delayed ||
                   seen.most_booked !== want.most_booked) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display({"%0t: booking mismatch: room %0d/%0d start %0h/%0h",
                               " finish %0h/%0h delayed %0b/%0b busiest %0d/%0d",
                               " (expected/actual)"},
                              $realtime, want.room, seen.room,
                              want.actual_start, seen.actual_start,
                              want.actual_finish, seen.actual_finish,
                              want.delayed, seen.delayed,
                              want.most_booked, seen.most_booked);
               end
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 23);
   end

   // ---------------------------------------------------------------------------
   // Watchdog: give up after a long run of cycles with no transaction
   // ---------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   function automatic plan_row_t plan(input row_kind_t kind, input logic [4:0] rooms,
                                      input logic [31:0] s, e, input bit c,
                                      input bit typed, input logic [3:0] room,
                                      input stamp_t t0, t1, input bit late,
                                      input logic [3:0] top);
      plan_row_t r;
      r.kind                  = kind;
      r.rooms                 = rooms;
      r.request.start_time    = s;
      r.request.end_time      = e;
      r.request.clear_first   = c;
      r.typed                 = typed;
      r.booking.room          = room;
      r.booking.actual_start  = t0;
      r.booking.actual_finish = t1;
      r.booking.delayed       = late;
      r.booking.most_booked   = top;
      return r;
   endfunction

   // present one request, idling at random first, and wait for the handshake
   task automatic send_job(input booking_request_t job, input bit typed,
                           input booking_t booking);
      while (!calm && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= {7'b0, job.clear_first, job.end_time, job.start_time};
      typed_valid   <= typed;
      typed_booking <= booking;
      do @(posedge clock); while (!req_tready);
      jobs_sent++;
   endtask

   // hold off the sender until every pending booking has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (results_seen != jobs_sent) @(posedge clock);
   endtask

   task automatic write_rooms(input logic [4:0] rooms);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rooms;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly ordered jobs with contention, plus malformed and random ones
   task automatic random_job(output booking_request_t job);
      int unsigned        kind;
      logic [32:0]        wide;
      kind            = $urandom_range(99);
      job.clear_first = ($urandom_range(99) < 2);
      if (kind < 6) begin
         job.start_time = $urandom;
         job.end_time   = $urandom;
      end else if (kind < 10) begin
         // start earlier than the stream
         job.start_time = cursor - $urandom_range(SPACING * 4);
         job.end_time   = job.start_time + $urandom_range(SPACING * 8, 1);
      end else begin
         if (kind < 12) cursor = $urandom;
         wide   = {1'b0, cursor} + $urandom_range(SPACING);
         cursor = wide[32] ? '1 : wide[31:0];
         job.start_time = cursor;
         if (kind < 16) begin
            // end not after start
            job.end_time = cursor - $urandom_range(3);
         end else begin
            wide = {1'b0, cursor} + $urandom_range(SPACING * 2 * MAX_ROOMS, 1);
            job.end_time = wide[32] ? '1 : wide[31:0];
         end
      end
   endtask

   initial begin : stimulus
      plan_row_t        row;
      booking_request_t job;
      booking_t         none;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      typed_valid = 1'b0;
      typed_booking = '0;
      none        = '0;
      phase_rooms = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd31, 5'd20, 5'd12};

      // directed table; typed rows are read straight off the booking rules
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd0, 32'd10, 0,
                                   1, 4'd0, 48'd0, 48'd10, 0, 4'd0));
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd0, 32'd5, 0,
                                   1, 4'd1, 48'd0, 48'd5, 0, 4'd0));
      // end equal to start, room free exactly at the start
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd5, 32'd5, 0,
                                   1, 4'd1, 48'd5, 48'd5, 0, 4'd1));
      // end before start at the top of the range; tie on count goes low
      directed_plan.push_back(plan(ROW_JOB, 0, 32'hFFFF_FFFF, 32'd0, 0,
                                   1, 4'd0, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 0, 4'd0));
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd0, 32'hFFFF_FFFF, 1,
                                   1, 4'd0, 48'd0, 48'hFFFF_FFFF, 0, 4'd0));
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd100, 32'd200, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      directed_plan.push_back(plan(ROW_CSR, 5'd1, 32'd0, 32'd0, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      // one room, busy: pushed back past 32 bits
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd300, 32'd350, 0,
                                   1, 4'd0, 48'hFFFF_FFFF, 48'h1_0000_0031, 1, 4'd0));
      // room count zero acts as one room
      directed_plan.push_back(plan(ROW_CSR, 5'd0, 32'd0, 32'd0, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd0, 32'hFFFF_FFFF, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      // oversize room count saturates; state is kept
      directed_plan.push_back(plan(ROW_CSR, 5'd31, 32'd0, 32'd0, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd400, 32'd500, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      // start out of order
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd50, 32'd60, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      directed_plan.push_back(plan(ROW_CSR, 5'd2, 32'd0, 32'd0, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd10, 32'd20, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      directed_plan.push_back(plan(ROW_CSR, 5'd16, 32'd0, 32'd0, 0,
                                   0, 4'd0, 48'd0, 48'd0, 0, 4'd0));
      directed_plan.push_back(plan(ROW_JOB, 0, 32'd7, 32'd7, 1,
                                   1, 4'd0, 48'd7, 48'd7, 0, 4'd0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_CSR)
            write_rooms(row.rooms);
         else
            send_job(row.request, row.typed, row.booking);
      end

      // one room, back to back long jobs: free time runs far past 32 bits
      calm = 1'b1;
      write_rooms(5'd1);
      job.start_time  = '0;
      job.end_time    = '1;
      job.clear_first = 1'b1;
      send_job(job, 1'b0, none);
      job.clear_first = 1'b0;
      repeat (SOAK_JOBS) send_job(job, 1'b0, none);
      calm = 1'b0;

      // random phases over several room counts; one phase without idling
      for (int p = 0; p < 8; p++) begin
         write_rooms(phase_rooms[p]);
         calm = (p == 3);
         repeat (PHASE_JOBS) begin
            random_job(job);
            send_job(job, 1'b0, none);
         end
      end

      drain();
      calm = 1'b0;
      repeat (40) @(posedge clock);
      if (expected_bookings.size() != 0) failures++;
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== room_booking_allocator.f =====
rtl/core/rba_pkg.sv
rtl/core/rba_store.sv
rtl/core/room_booking_allocator.sv
tb/tb.sv
